### rtl/integer_set_table_macros.svh
// assertion macros for the integer set table checker
`ifndef INTEGER_SET_TABLE_MACROS_SVH
`define INTEGER_SET_TABLE_MACROS_SVH

// same-cycle implication
`define IST_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integer_set_table check failed");

// next-cycle implication
`define IST_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integer_set_table check failed");

`endif

### rtl/ist_pkg.sv
`default_nettype none
package ist_pkg;

  localparam int OPCODE_W     = 2;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 5;
  localparam int CAPACITY_DEF = 16;

  localparam logic [OPCODE_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CONTAINS = 2'd2;

  typedef struct packed {
    logic tok;
    logic fnd;
  } link_t;

  typedef struct packed {
    logic remove;
    logic write;
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/ist_cell.sv
`default_nettype none
module ist_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ist_pkg::cell_ctl_t            ctl,
  input  wire logic [ist_pkg::VALUE_W-1:0]   value,
  input  wire logic [CNT_W-1:0]              count,
  input  wire ist_pkg::link_t                link_i,
  output ist_pkg::link_t                     link_o,
  input  wire logic                          shift_i,
  output logic                               shift_o,
  input  wire logic [ist_pkg::VALUE_W-1:0]   data_i,
  output logic [ist_pkg::VALUE_W-1:0]        data_o
);
  import ist_pkg::*;

  logic               tok_r;
  logic               fnd_r;
  logic [VALUE_W-1:0] entry_r;
  logic [VALUE_W-1:0] entry_nxt;
  logic               occupied;
  logic               match;

  assign occupied = count > CNT_W'(IDX);
  assign match    = tok_r && occupied && (entry_r == value);

  assign link_o.tok = tok_r;
  assign link_o.fnd = fnd_r || match;
  assign shift_o    = tok_r && fnd_r && ctl.remove;
  assign data_o     = entry_r;

  always_comb begin
    priority if (ctl.write && (count == CNT_W'(IDX))) begin
      entry_nxt = value;
    end else if (shift_i) begin
      entry_nxt = data_i;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
      fnd_r <= 1'b0;
    end else begin
      tok_r <= link_i.tok;
      fnd_r <= link_i.fnd;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

### rtl/integer_set_table.sv
// Set of up to CAPACITY distinct 32-bit words kept in insertion order. Each
// input word carries an opcode (add, remove, membership test; the unused code
// acts as a test) and a value, and yields one result word: found (value was
// present before), count after, empty flag, and rejected (add of a new value
// to a full store). Entries sit in a row of cells; an item sends a token down
// the row one cell per cycle, each cell comparing its entry and, on a remove,
// pulling its right neighbor's entry down to close the gap. An item's result
// is committed to the output register once the token leaves the last cell;
// the commit waits while an earlier result is still untaken. A new item is
// accepted only in the idle state. The result sits in an output register, so
// the next word is taken while a result waits.
`default_nettype none
module integer_set_table #(
  parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [ist_pkg::OPCODE_W-1:0]         in_opcode,
  input  wire logic signed [ist_pkg::VALUE_W-1:0]   in_value,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_found,
  output logic [ist_pkg::COUNT_W-1:0]               out_count,
  output logic                                      out_empty_res,
  output logic                                      out_rejected
);
  import ist_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [OPCODE_W-1:0] op_r;
  logic [VALUE_W-1:0]  value_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                found_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_empty_r;
  logic                out_rej_r;
  logic                rej_nxt;
  logic                accept;
  logic                commit;
  logic                full;
  cell_ctl_t           ctl;

  link_t               lnk [CAPACITY+1];
  logic [VALUE_W-1:0]  ent [CAPACITY+1];
  logic                sh  [CAPACITY+1];

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign full     = (count_r == CNT_W'(CAPACITY));

  assign lnk[0].tok    = accept;
  assign lnk[0].fnd    = 1'b0;
  assign ent[CAPACITY] = '0;
  assign sh[CAPACITY]  = 1'b0;

  assign ctl.remove = (op_r == OP_REMOVE);
  assign ctl.write  = commit && (op_r == OP_ADD) && !found_r && !full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ist_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .value   (value_r),
      .count   (count_r),
      .link_i  (lnk[i]),
      .link_o  (lnk[i+1]),
      .shift_i (sh[i+1]),
      .shift_o (sh[i]),
      .data_i  (ent[i+1]),
      .data_o  (ent[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    rej_nxt   = 1'b0;
    unique case (op_r)
      OP_ADD: begin
        if (!found_r) begin
          if (full) begin
            rej_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      OP_REMOVE: begin
        if (found_r) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (lnk[CAPACITY].tok) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      value_r <= in_value;
    end
    if ((state_r == ST_RUN) && lnk[CAPACITY].tok) begin
      found_r <= lnk[CAPACITY].fnd;
    end
    if (commit) begin
      out_found_r <= found_r;
      out_count_r <= COUNT_W'(count_nxt);
      out_empty_r <= (count_nxt == '0);
      out_rej_r   <= rej_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_count     = out_count_r;
  assign out_empty_res = out_empty_r;
  assign out_rejected  = out_rej_r;

endmodule
`default_nettype wire

### rtl/ist_checker.sv
`default_nettype none
`include "integer_set_table_macros.svh"
module ist_checker #(
  parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_ready,
  input  wire logic [ist_pkg::OPCODE_W-1:0]         in_opcode,
  input  wire logic signed [ist_pkg::VALUE_W-1:0]   in_value,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_ready,
  input  wire logic                                 out_found,
  input  wire logic [ist_pkg::COUNT_W-1:0]          out_count,
  input  wire logic                                 out_empty_res,
  input  wire logic                                 out_rejected
);
  import ist_pkg::*;

  logic [COUNT_W-1:0] cap_count;

  assign cap_count = COUNT_W'(CAPACITY);

  `IST_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
    in_valid && $stable(in_opcode) && $stable(in_value))

  `IST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_found) && $stable(out_count)
    && $stable(out_empty_res) && $stable(out_rejected))

  `IST_ASSERT_IMPL(a_empty_count, clk, rst_n, out_valid,
    (out_empty_res == (out_count == '0)) || (CAPACITY > 31))

  `IST_ASSERT_IMPL(a_reject_full, clk, rst_n, out_valid && out_rejected,
    !out_found && (out_count == cap_count))

  `IST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind integer_set_table ist_checker #(.CAPACITY(CAPACITY)) u_ist_checker (.*);
`default_nettype wire
